// File: rtl/esc_pkg.sv
// Shared constants, types and the CRC-8 step function of the ESC telemetry poller.
`timescale 1ns / 1ps

package esc_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int FRAME_LEN   = 10;

  localparam int MOTOR_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int CNT_W   = $clog2(FRAME_LEN + 1);
  localparam int IDX_W   = $clog2(FRAME_LEN);

  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int MASK_W  = 4;
  localparam int ERPM_W  = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIME         = 1'd1;

  localparam logic [CFG_W-1:0] RESPONSE_TIMEOUT_RST = 16'd500;
  localparam logic [CFG_W-1:0] GAP_TIME_RST         = 16'd100;

  localparam logic [7:0] CRC_POLY = 8'h07;

  // raw * 100 / 6 == raw * 50 / 3, done as raw * (50 * ceil(2^25 / 3)) >> 25.
  localparam int          ERPM_MUL_W = 30;
  localparam int          ERPM_SHIFT = 25;
  localparam logic [ERPM_MUL_W-1:0] ERPM_MUL = 30'd559240550;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_BYTE = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    PH_REQUEST = 2'd0,
    PH_WAIT    = 2'd1,
    PH_ADVANCE = 2'd2,
    PH_GAP     = 2'd3
  } phase_e;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  typedef struct packed {
    logic       clear;
    logic       store;
    logic [7:0] data;
  } rx_ctrl_t;

  typedef struct packed {
    logic       frame_ready;
    logic       crc_ok;
    frame_t     bytes;
  } rx_status_t;

  typedef struct packed {
    logic [MASK_W-1:0] request_mask;
    logic              frame_done;
    logic              crc_error;
    logic              timed_out;
    logic [1:0]        motor_index;
    logic [7:0]        temperature;
    logic [15:0]       voltage_centivolts;
    logic [15:0]       current_centiamps;
    logic [15:0]       consumption;
    logic [ERPM_W-1:0] erpm;
  } result_t;

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage

// File: rtl/esc_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface esc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [esc_pkg::TIME_W-1:0] now;
  logic [7:0]                 rx_byte;

  modport source(output valid, req_type, now, rx_byte, input ready);
  modport sink(input valid, req_type, now, rx_byte, output ready);
endinterface

interface esc_out_if;
  logic                       valid;
  logic                       ready;
  logic [esc_pkg::MASK_W-1:0] request_mask;
  logic                       frame_done;
  logic                       crc_error;
  logic                       timed_out;
  logic [1:0]                 motor_index;
  logic [7:0]                 temperature;
  logic [15:0]                voltage_centivolts;
  logic [15:0]                current_centiamps;
  logic [15:0]                consumption;
  logic [esc_pkg::ERPM_W-1:0] erpm;

  modport source(output valid, request_mask, frame_done, crc_error, timed_out, motor_index,
                 temperature, voltage_centivolts, current_centiamps, consumption, erpm,
                 input ready);
  modport sink(input valid, request_mask, frame_done, crc_error, timed_out, motor_index,
               temperature, voltage_centivolts, current_centiamps, consumption, erpm,
               output ready);
endinterface

// File: rtl/esc_telemetry_poller.sv
// Top level of the ESC telemetry poller: input register, poll sequencer, decode, result register.
// A result passes through the input register and then the result register before it is valid.
// Throughput: one item per cycle; ready drops only while the input register holds an item and
// the result register is held by the sink.
// Reset clears the sequencer, the motor position, the request mask, the receiver and both
// configuration registers (response timeout 500, gap time 100); the frame byte store is not reset.
`timescale 1ns / 1ps

module esc_telemetry_poller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [esc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [esc_pkg::CFG_W-1:0]     cfg_wdata_i,
  esc_in_if.sink                        in_ch_i,
  esc_out_if.source                     out_ch_o
);

  localparam int PROD_W = 16 + esc_pkg::ERPM_MUL_W;

  logic [esc_pkg::CFG_W-1:0] timeout_q, gap_q;

  logic                       s1_valid_q;
  logic                       s1_type_q;
  logic [esc_pkg::TIME_W-1:0] s1_now_q;
  logic [7:0]                 s1_byte_q;

  logic                       res_valid_q;
  esc_pkg::result_t           res_q, res_d;

  esc_pkg::phase_e            phase_q, phase_d;
  logic [esc_pkg::MOTOR_W-1:0] motor_q, motor_d;
  logic [esc_pkg::MASK_W-1:0] req_bits_q, req_bits_d;
  logic [esc_pkg::TIME_W-1:0] last_time_q, last_time_d;

  esc_pkg::rx_ctrl_t          rx_ctrl;
  esc_pkg::rx_status_t        rx_status;

  logic                       res_load, s1_fire;
  logic [esc_pkg::TIME_W-1:0] elapsed;
  logic [1:0]                 motor_idx;
  logic [8:0][7:0]            pad;
  logic [15:0]                erpm_raw;
  logic [PROD_W-1:0]          erpm_prod;
  logic [esc_pkg::MASK_W-1:0] mask_next;

  esc_frame_rx u_frame_rx (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (rx_ctrl),
    .status_o (rx_status)
  );

  for (genvar k = 0; k < 9; k++) begin : g_pad
    if (k < esc_pkg::FRAME_LEN) begin : g_byte
      assign pad[k] = rx_status.bytes[k];
    end else begin : g_zero
      assign pad[k] = '0;
    end
  end

  for (genvar j = 0; j < esc_pkg::MASK_W; j++) begin : g_mask
    if (j < esc_pkg::MOTOR_COUNT) begin : g_bit
      assign mask_next[j] = (motor_q == esc_pkg::MOTOR_W'(j));
    end else begin : g_none
      assign mask_next[j] = 1'b0;
    end
  end

  assign res_load       = !res_valid_q || out_ch_o.ready;
  assign s1_fire        = s1_valid_q && res_load;
  assign in_ch_i.ready  = !s1_valid_q || s1_fire;

  assign elapsed   = s1_now_q - last_time_q;
  assign motor_idx = 2'(motor_q);
  assign erpm_raw  = {pad[7], pad[8]};
  assign erpm_prod = PROD_W'(erpm_raw) * PROD_W'(esc_pkg::ERPM_MUL);

  always_comb begin
    phase_d     = phase_q;
    motor_d     = motor_q;
    req_bits_d  = req_bits_q;
    last_time_d = last_time_q;
    rx_ctrl     = '0;
    rx_ctrl.data = s1_byte_q;
    res_d       = '0;
    if (s1_fire) begin
      if (s1_type_q == esc_pkg::REQ_BYTE) begin
        rx_ctrl.store = (phase_q == esc_pkg::PH_WAIT);
      end else begin
        unique case (phase_q)
          esc_pkg::PH_REQUEST: begin
            req_bits_d    = mask_next;
            rx_ctrl.clear = 1'b1;
            last_time_d   = s1_now_q;
            phase_d       = esc_pkg::PH_WAIT;
          end
          esc_pkg::PH_WAIT: begin
            if (rx_status.frame_ready) begin
              res_d.motor_index = motor_idx;
              if (rx_status.crc_ok) begin
                res_d.frame_done         = 1'b1;
                res_d.temperature        = pad[0];
                res_d.voltage_centivolts = {pad[1], pad[2]};
                res_d.current_centiamps  = {pad[3], pad[4]};
                res_d.consumption        = {pad[5], pad[6]};
                res_d.erpm = erpm_prod[esc_pkg::ERPM_SHIFT +: esc_pkg::ERPM_W];
              end else begin
                res_d.crc_error = 1'b1;
              end
              phase_d = esc_pkg::PH_ADVANCE;
            end else if (elapsed > esc_pkg::TIME_W'(timeout_q)) begin
              res_d.timed_out   = 1'b1;
              res_d.motor_index = motor_idx;
              phase_d           = esc_pkg::PH_REQUEST;
            end
          end
          esc_pkg::PH_ADVANCE: begin
            if (motor_q == esc_pkg::MOTOR_W'(esc_pkg::MOTOR_COUNT - 1)) begin
              motor_d = '0;
            end else begin
              motor_d = motor_q + 1'b1;
            end
            last_time_d = s1_now_q;
            phase_d     = esc_pkg::PH_GAP;
          end
          esc_pkg::PH_GAP: begin
            if (elapsed > esc_pkg::TIME_W'(gap_q)) begin
              last_time_d = s1_now_q;
              phase_d     = esc_pkg::PH_REQUEST;
            end
          end
          default: begin
            phase_d = esc_pkg::PH_REQUEST;
          end
        endcase
      end
    end
    res_d.request_mask = req_bits_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= esc_pkg::RESPONSE_TIMEOUT_RST;
      gap_q       <= esc_pkg::GAP_TIME_RST;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      phase_q     <= esc_pkg::PH_REQUEST;
      motor_q     <= '0;
      req_bits_q  <= '0;
      last_time_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          esc_pkg::CFG_RESPONSE_TIMEOUT: timeout_q <= cfg_wdata_i;
          esc_pkg::CFG_GAP_TIME:         gap_q     <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_ch_i.ready) begin
        s1_valid_q <= in_ch_i.valid;
      end
      if (res_load) begin
        res_valid_q <= s1_valid_q;
      end
      phase_q     <= phase_d;
      motor_q     <= motor_d;
      req_bits_q  <= req_bits_d;
      last_time_q <= last_time_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.ready && in_ch_i.valid) begin
      s1_type_q <= in_ch_i.req_type;
      s1_now_q  <= in_ch_i.now;
      s1_byte_q <= in_ch_i.rx_byte;
    end
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign out_ch_o.valid              = res_valid_q;
  assign out_ch_o.request_mask       = res_q.request_mask;
  assign out_ch_o.frame_done         = res_q.frame_done;
  assign out_ch_o.crc_error          = res_q.crc_error;
  assign out_ch_o.timed_out          = res_q.timed_out;
  assign out_ch_o.motor_index        = res_q.motor_index;
  assign out_ch_o.temperature        = res_q.temperature;
  assign out_ch_o.voltage_centivolts = res_q.voltage_centivolts;
  assign out_ch_o.current_centiamps  = res_q.current_centiamps;
  assign out_ch_o.consumption        = res_q.consumption;
  assign out_ch_o.erpm               = res_q.erpm;

endmodule

// File: rtl/esc_frame_rx.sv
// Telemetry frame receiver: byte store, byte counter and running CRC-8.
`timescale 1ns / 1ps

module esc_frame_rx (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  esc_pkg::rx_ctrl_t   ctrl_i,
  output esc_pkg::rx_status_t status_o
);

  logic [esc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      ready_q, ready_d;
  logic [7:0]                crc_q, crc_d;
  esc_pkg::frame_t           bytes_q;
  logic                      wr_en;

  assign wr_en = ctrl_i.store && !ready_q &&
                 (cnt_q < esc_pkg::CNT_W'(esc_pkg::FRAME_LEN));

  always_comb begin
    cnt_d   = cnt_q;
    ready_d = ready_q;
    crc_d   = crc_q;
    if (ctrl_i.clear) begin
      cnt_d   = '0;
      ready_d = 1'b0;
      crc_d   = '0;
    end else if (wr_en) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q < esc_pkg::CNT_W'(esc_pkg::FRAME_LEN - 1)) begin
        crc_d = esc_pkg::crc8_step(crc_q, ctrl_i.data);
      end
      if (cnt_q == esc_pkg::CNT_W'(esc_pkg::FRAME_LEN - 1)) begin
        ready_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ready_q <= 1'b0;
      crc_q   <= '0;
    end else begin
      cnt_q   <= cnt_d;
      ready_q <= ready_d;
      crc_q   <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && !ctrl_i.clear) begin
      bytes_q[cnt_q[esc_pkg::IDX_W-1:0]] <= ctrl_i.data;
    end
  end

  assign status_o.frame_ready = ready_q;
  assign status_o.crc_ok      = (crc_q == bytes_q[esc_pkg::FRAME_LEN-1]);
  assign status_o.bytes       = bytes_q;

endmodule

// File: rtl/esc_checker.sv
// Port-level assertions for the ESC telemetry poller and the bind that attaches them.
`timescale 1ns / 1ps

module esc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [esc_pkg::MASK_W-1:0] request_mask_i,
  input logic                       frame_done_i,
  input logic                       crc_error_i,
  input logic                       timed_out_i,
  input logic [1:0]                 motor_index_i,
  input logic [7:0]                 temperature_i,
  input logic [15:0]                voltage_centivolts_i,
  input logic [15:0]                current_centiamps_i,
  input logic [15:0]                consumption_i,
  input logic [esc_pkg::ERPM_W-1:0] erpm_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(frame_done_i) && $stable(erpm_i) &&
      $stable(request_mask_i) && $stable(motor_index_i))
    else $error("Result changed while a transfer was stalled.");

  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $countones({frame_done_i, crc_error_i, timed_out_i}) <= 1)
    else $error("More than one completion flag set in one result.");

  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !frame_done_i |-> temperature_i == '0 && voltage_centivolts_i == '0 &&
      current_centiamps_i == '0 && consumption_i == '0 && erpm_i == '0)
    else $error("Telemetry fields nonzero without a decoded frame.");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !frame_done_i && !crc_error_i && !timed_out_i |-> motor_index_i == '0)
    else $error("Motor index set without a completion flag.");

  a_mask_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0(request_mask_i))
    else $error("Request mask is not one-hot.");

endmodule

bind esc_telemetry_poller esc_checker u_esc_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (out_ch_o.valid),
  .out_ready_i          (out_ch_o.ready),
  .request_mask_i       (out_ch_o.request_mask),
  .frame_done_i         (out_ch_o.frame_done),
  .crc_error_i          (out_ch_o.crc_error),
  .timed_out_i          (out_ch_o.timed_out),
  .motor_index_i        (out_ch_o.motor_index),
  .temperature_i        (out_ch_o.temperature),
  .voltage_centivolts_i (out_ch_o.voltage_centivolts),
  .current_centiamps_i  (out_ch_o.current_centiamps),
  .consumption_i        (out_ch_o.consumption),
  .erpm_i               (out_ch_o.erpm)
);
